// File: src/mkpd_pkg.sv
// ----------------------------------------------------------------------------
// mkpd_pkg
// Shared types and the key character table for the keypad scan debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package mkpd_pkg;

  localparam int unsigned ROWS     = 4;
  localparam int unsigned COLS     = 4;
  localparam int unsigned ROW_W    = $clog2(ROWS);
  localparam int unsigned COL_W    = $clog2(COLS);
  localparam int unsigned KEY_W    = ROW_W + COL_W;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned NUM_KEYS = ROWS * COLS;

  typedef struct packed {
    logic [COLS-1:0] cols_row0;
    logic [COLS-1:0] cols_row1;
    logic [COLS-1:0] cols_row2;
    logic [COLS-1:0] cols_row3;
  } scan_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_index;
    logic [CHAR_W-1:0] key_char;
  } key_t;

  // what one row lane found
  typedef struct packed {
    logic             hit;
    logic [COL_W-1:0] col;
  } lane_hit_t;

  // decision of the merge stage for the scan on the input
  typedef struct packed {
    logic emit;
    key_t item;
  } merge_out_t;

  // remapped layout "abodefchijglmnkp"
  localparam logic [CHAR_W-1:0] KEY_CHARS [NUM_KEYS] = '{
    7'h61, 7'h62, 7'h6f, 7'h64, 7'h65, 7'h66, 7'h63, 7'h68,
    7'h69, 7'h6a, 7'h67, 7'h6c, 7'h6d, 7'h6e, 7'h6b, 7'h70
  };

endpackage

`default_nettype wire

// File: src/matrix_keypad_scan_debounce.sv
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce
// 4x4 keypad scan decode with two-scan debounce and buffered key output.
// ----------------------------------------------------------------------------
// One scan is taken per cycle while scan_ready is high: four row lanes decode
// their column samples in parallel, the merge stage picks the first row with a
// single key and compares it with the held key in the same cycle. A debounced
// key leaves through an output register backed by one skid entry, so scans keep
// flowing while a key waits; scan_ready drops only when both entries are full.
`default_nettype none

module matrix_keypad_scan_debounce (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            scan_valid,
  output      logic            scan_ready,
  input  wire mkpd_pkg::scan_t scan,
  output      logic            key_valid,
  input  wire logic            key_ready,
  output mkpd_pkg::key_t       key
);
  import mkpd_pkg::*;

  lane_hit_t  lanes [ROWS];
  merge_out_t result;
  logic       scan_fire;
  logic       key_fire;
  logic       push;
  logic       skid_valid;
  key_t       skid;

  mkpd_lane u_lane0 (.cols(scan.cols_row0), .lane(lanes[0]));
  mkpd_lane u_lane1 (.cols(scan.cols_row1), .lane(lanes[1]));
  mkpd_lane u_lane2 (.cols(scan.cols_row2), .lane(lanes[2]));
  mkpd_lane u_lane3 (.cols(scan.cols_row3), .lane(lanes[3]));

  mkpd_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .fire   (scan_fire),
    .lanes  (lanes),
    .result (result)
  );

  assign scan_ready = !skid_valid;
  assign scan_fire  = scan_valid && scan_ready;
  assign key_fire   = key_valid && key_ready;
  assign push       = scan_fire && result.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (key_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!key_valid || key_fire) begin
        key_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (key_fire) begin
      key_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (key_fire) begin
        key <= skid;
      end
    end else if (push) begin
      if (!key_valid || key_fire) begin
        key <= result.item;
      end else begin
        skid <= result.item;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> key_valid)
    else $error("skid entry held with empty output register");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    push && key_valid && !key_ready |=> skid_valid)
    else $error("key lost while output stalled");

  a_skid_moves: assert property (@(posedge clk) disable iff (rst)
    skid_valid && key_ready |=> key_valid && key == $past(skid))
    else $error("skid entry not moved to output");

endmodule

`default_nettype wire

// File: src/mkpd_lane.sv
// ----------------------------------------------------------------------------
// mkpd_lane
// One row lane: finds whether exactly one column is active and which one.
// ----------------------------------------------------------------------------
`default_nettype none

module mkpd_lane (
  input  wire logic [mkpd_pkg::COLS-1:0] cols,
  output mkpd_pkg::lane_hit_t            lane
);
  import mkpd_pkg::*;

  always_comb begin
    lane.hit = 1'b0;
    lane.col = '0;
    case (cols)
      4'b0001: begin
        lane.hit = 1'b1;
        lane.col = 2'd0;
      end
      4'b0010: begin
        lane.hit = 1'b1;
        lane.col = 2'd1;
      end
      4'b0100: begin
        lane.hit = 1'b1;
        lane.col = 2'd2;
      end
      4'b1000: begin
        lane.hit = 1'b1;
        lane.col = 2'd3;
      end
      default: begin
        lane.hit = 1'b0;
        lane.col = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/mkpd_merge.sv
// ----------------------------------------------------------------------------
// mkpd_merge
// Picks the first row lane with a single key and runs the two-scan debounce.
// ----------------------------------------------------------------------------
`default_nettype none

module mkpd_merge (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire mkpd_pkg::lane_hit_t lanes [mkpd_pkg::ROWS],
  output mkpd_pkg::merge_out_t     result
);
  import mkpd_pkg::*;

  logic             held_valid;
  logic             held_valid_next;
  logic [KEY_W-1:0] held_key;
  logic [KEY_W-1:0] held_key_next;
  logic             pressed;
  logic [KEY_W-1:0] key;

  // lowest row wins
  always_comb begin
    pressed = 1'b0;
    key     = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (lanes[r].hit) begin
        pressed = 1'b1;
        key     = {ROW_W'(r), lanes[r].col};
      end
    end
  end

  always_comb begin
    result.emit          = held_valid && pressed && (key == held_key);
    result.item.key_index = key;
    result.item.key_char  = KEY_CHARS[key];
    held_valid_next = !held_valid && pressed;
    held_key_next   = (!held_valid && pressed) ? key : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_key   <= '0;
    end else if (fire) begin
      held_valid <= held_valid_next;
      held_key   <= held_key_next;
    end
  end

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    fire && result.emit |=> !held_valid)
    else $error("held key not cleared after emit");

  a_first_loads: assert property (@(posedge clk) disable iff (rst)
    fire && !held_valid && pressed |=> held_valid && held_key == $past(key))
    else $error("first press not held");

  a_no_press_clears: assert property (@(posedge clk) disable iff (rst)
    fire && !pressed |=> !held_valid)
    else $error("held key survived a scan with no press");

endmodule

`default_nettype wire

// File: bench/matrix_keypad_scan_debounce_tb.sv
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce_tb
// Self-checking bench for the keypad scan decoder and two-scan debouncer.
// Keypad scans are sent through the input handshake, and each accepted scan
// updates a local debounce predictor. Each key transfer on the output is
// checked against the oldest predicted key. The scans cover the edge keys,
// rows with several keys, and every debounce case. Random press sequences
// follow, with and without idle gaps on both sides, and then a long output stall.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_debounce_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mkpd_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  scan_valid = 1'b0;
  logic  scan_ready;
  scan_t scan_item = '0;
  logic  key_valid;
  logic  key_ready = 1'b0;
  key_t  key_item;

  // debounce predictor state
  bit          held_valid = 1'b0;
  logic [3:0]  held_idx = '0;
  string       key_layout = "abodefchijglmnkp";

  key_t expected_keys[$];
  int   failures = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_request = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  matrix_keypad_scan_debounce i_dut (
    .clk        (clk),
    .rst        (rst),
    .scan_valid (scan_valid),
    .scan_ready (scan_ready),
    .scan       (scan_item),
    .key_valid  (key_valid),
    .key_ready  (key_ready),
    .key        (key_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit debounce_scan(input scan_t s, output key_t k);
    logic [3:0] rows [4];
    bit         pressed;
    logic [3:0] idx;
    byte        ch;
    rows[0] = s.cols_row0;
    rows[1] = s.cols_row1;
    rows[2] = s.cols_row2;
    rows[3] = s.cols_row3;
    pressed = 1'b0;
    idx     = '0;
    k       = '0;
    for (int r = 0; r < 4; r++) begin
      if (!pressed && $countones(rows[r]) == 1) begin
        pressed = 1'b1;
        for (int c = 0; c < 4; c++) begin
          if (rows[r][c]) idx = 4'(4 * r + c);
        end
      end
    end
    if (!held_valid && pressed) begin
      held_valid = 1'b1;
      held_idx   = idx;
      return 1'b0;
    end
    if (held_valid && pressed && idx == held_idx) begin
      ch          = key_layout[int'(idx)];
      k.key_index = idx;
      k.key_char  = ch[6:0];
      held_valid  = 1'b0;
      held_idx    = '0;
      return 1'b1;
    end
    held_valid = 1'b0;
    held_idx   = '0;
    return 1'b0;
  endfunction

  function automatic scan_t scan_rows(input logic [3:0] r0, r1, r2, r3);
    scan_t s;
    s.cols_row0 = r0;
    s.cols_row1 = r1;
    s.cols_row2 = r2;
    s.cols_row3 = r3;
    return s;
  endfunction

  // any row sample that does not decode to a single key
  function automatic logic [3:0] noise_row();
    logic [3:0] v;
    do v = 4'($urandom_range(15)); while ($countones(v) == 1);
    return v;
  endfunction

  // scan that decodes to key idx, with random content elsewhere
  function automatic scan_t scan_for_key(input int idx);
    logic [3:0] rows [4];
    for (int r = 0; r < 4; r++) begin
      if (r < idx / 4)       rows[r] = noise_row();
      else if (r == idx / 4) rows[r] = 4'(1 << (idx % 4));
      else                   rows[r] = 4'($urandom_range(15));
    end
    return scan_rows(rows[0], rows[1], rows[2], rows[3]);
  endfunction

  task automatic offer_scan(input scan_t s);
    key_t k;
    while ($urandom_range(99) < send_idle_pct) begin
      scan_valid <= 1'b0;
      @(posedge clk);
    end
    scan_valid <= 1'b1;
    scan_item  <= s;
    @(posedge clk);
    while (!scan_ready) @(posedge clk);
    if (debounce_scan(s, k)) expected_keys.push_back(k);
  endtask

  // output side: random ready, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      key_ready <= 1'b0;
      hold_left--;
    end else begin
      key_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_key
    key_t want;
    if (!rst && key_valid && key_ready) begin
      if (expected_keys.size() == 0) begin
        $error("unexpected key transfer: key_index %0d key_char %0h",
               key_item.key_index, key_item.key_char);
        failures++;
      end else begin
        want = expected_keys.pop_front();
        if (key_item.key_index !== want.key_index) begin
          $error("key_index: expected %0d, got %0d", want.key_index, key_item.key_index);
          failures++;
        end
        if (key_item.key_char !== want.key_char) begin
          $error("key_char: expected %0h, got %0h", want.key_char, key_item.key_char);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((scan_valid && scan_ready) || (key_valid && key_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("matrix_keypad_scan_debounce_tb: FAIL");
      $finish;
    end
  end

  task automatic test_directed_keys();
    // single keys at both corners
    repeat (2) offer_scan(scan_rows(4'h1, 4'h0, 4'h0, 4'h0));
    repeat (2) offer_scan(scan_rows(4'h0, 4'h0, 4'h0, 4'h8));
    // rows with several keys are skipped
    repeat (2) offer_scan(scan_rows(4'hf, 4'h4, 4'h1, 4'h2));
    repeat (2) offer_scan(scan_rows(4'h3, 4'hf, 4'h6, 4'h8));
    // no press: empty and all-pressed scans
    offer_scan(scan_rows(4'h0, 4'h0, 4'h0, 4'h0));
    offer_scan(scan_rows(4'hf, 4'hf, 4'hf, 4'hf));
    // different key drops the held one without loading the new one
    offer_scan(scan_rows(4'h8, 4'h0, 4'h0, 4'h0));
    repeat (3) offer_scan(scan_rows(4'h0, 4'h2, 4'h0, 4'h0));
    // release between presses
    offer_scan(scan_rows(4'h0, 4'h0, 4'h2, 4'h0));
    offer_scan(scan_rows(4'h0, 4'h0, 4'h0, 4'h0));
    repeat (2) offer_scan(scan_rows(4'h0, 4'h0, 4'h2, 4'h0));
    // key held down: every second scan gives a key
    repeat (4) offer_scan(scan_rows(4'h0, 4'h0, 4'h4, 4'h0));
  endtask

  task automatic test_random_scans(input int n, input int s_pct, input int r_pct);
    int sent;
    int pick;
    int k;
    int other;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      k    = $urandom_range(15);
      if (pick < 60) begin
        repeat (2) offer_scan(scan_for_key(k));
        sent += 2;
      end else if (pick < 75) begin
        repeat (3) offer_scan(scan_for_key(k));
        sent += 3;
      end else if (pick < 85) begin
        other = (k + $urandom_range(1, 15)) % 16;
        offer_scan(scan_for_key(k));
        offer_scan(scan_for_key(other));
        offer_scan(scan_for_key(other));
        sent += 3;
      end else if (pick < 92) begin
        offer_scan(scan_for_key(k));
        offer_scan(scan_rows(noise_row(), noise_row(), noise_row(), noise_row()));
        offer_scan(scan_for_key(k));
        sent += 3;
      end else begin
        offer_scan(scan_t'($urandom_range(16'hffff)));
        sent += 1;
      end
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    for (int i = 0; i < 24; i++) begin
      repeat (2) offer_scan(scan_for_key(i % 16));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 59;
    test_directed_keys();
    test_random_scans(520, 36, 59);
    test_random_scans(520, 59, 36);
    test_random_scans(520, 0, 0);
    test_output_backpressure();
    scan_valid <= 1'b0;
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("matrix_keypad_scan_debounce_tb: PASS");
    end else begin
      $display("matrix_keypad_scan_debounce_tb: FAIL");
    end
    $finish;
  end

endmodule
